// ===== rtl/rae_pkg.sv =====
// Shared types and constants for the register ALU execute unit.
package rae_pkg;

    localparam int RAE_REG_COUNT = 256;

    localparam logic [3:0] OP_MOV = 4'd0;
    localparam logic [3:0] OP_INC = 4'd1;
    localparam logic [3:0] OP_DEC = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd3;
    localparam logic [3:0] OP_SUB = 4'd4;
    localparam logic [3:0] OP_MUL = 4'd5;
    localparam logic [3:0] OP_DIV = 4'd6;
    localparam logic [3:0] OP_CMP = 4'd7;
    localparam logic [3:0] OP_JMP = 4'd8;
    localparam logic [3:0] OP_JNE = 4'd9;
    localparam logic [3:0] OP_JE  = 4'd10;
    localparam logic [3:0] OP_JGE = 4'd11;
    localparam logic [3:0] OP_JG  = 4'd12;
    localparam logic [3:0] OP_JLE = 4'd13;
    localparam logic [3:0] OP_JL  = 4'd14;

    localparam logic [1:0] CMP_NE = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;
    localparam logic [1:0] CMP_LT = 2'd3;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [7:0]         a_reg;
        logic               a_is_imm;
        logic signed [63:0] a_imm;
        logic [7:0]         b_reg;
        logic               b_is_imm;
        logic signed [63:0] b_imm;
    } t_req;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         compare_state;
        logic               take_jump;
        logic               div_error;
    } t_rsp;

    typedef struct packed {
        logic mul_go;
        logic div_go;
    } t_md_ctrl;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_md_stat;

endpackage

// ===== rtl/rae_regfile.sv =====
// Register file memory with two registered read ports and per-entry valid bits.
module rae_regfile #(
    parameter int REG_COUNT = 256,
    parameter int AW        = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_a_addr,
    input  logic [AW-1:0] i_rd_b_addr,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_data,
    output logic [63:0]   o_rd_a,
    output logic [63:0]   o_rd_b
);
    import rae_pkg::*;

    logic [63:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [63:0]          r_rd_a;
    logic [63:0]          r_rd_b;
    logic                 r_va;
    logic                 r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_a_addr];
            r_rd_b <= r_mem[i_rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_va <= r_vld[i_rd_a_addr];
                r_vb <= r_vld[i_rd_b_addr];
            end
        end
    end

    assign o_rd_a = r_va ? r_rd_a : '0;
    assign o_rd_b = r_vb ? r_rd_b : '0;

endmodule

// ===== rtl/rae_muldiv.sv =====
// Multiply/divide wrapper seen by the sequencer; the datapath sits in rae_md.
module rae_muldiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rae_pkg::t_md_ctrl    i_ctrl,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    output rae_pkg::t_md_stat    o_stat
);
    import rae_pkg::*;

    rae_md u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (i_ctrl),
        .i_a     (i_a),
        .i_b     (i_b),
        .o_stat  (o_stat)
    );

endmodule

// ===== rtl/rae_md.sv =====
// Multi-cycle 64-bit multiplier (32x32 partial products) and bit-serial signed divider.
module rae_md (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rae_pkg::t_md_ctrl    i_ctrl,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    output rae_pkg::t_md_stat    o_stat
);
    import rae_pkg::*;

    logic        r_mul;
    logic        r_div;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [63:0] r_res;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic        r_neg;

    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [64:0] w_rsh;
    logic [63:0] w_prod_sh;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_ma = r_a[31:0];
                w_mb = r_b[31:0];
            end
            2'd1: begin
                w_ma = r_a[31:0];
                w_mb = r_b[63:32];
            end
            default: begin
                w_ma = r_a[63:32];
                w_mb = r_b[31:0];
            end
        endcase
    end

    assign w_rsh     = {r_rem[63:0], r_quo[63]};
    assign w_prod_sh = {r_prod[31:0], 32'd0};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_go) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (i_ctrl.div_go) begin
            r_rem <= '0;
            r_quo <= i_a[63] ? (64'd0 - i_a) : i_a;
            r_b   <= i_b[63] ? (64'd0 - i_b) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
        end
        if (r_mul) begin
            r_prod <= 64'(w_ma * w_mb);
            case (r_cnt[1:0])
                2'd1: r_acc <= r_prod;
                2'd2: r_acc <= r_acc + w_prod_sh;
                2'd3: r_res <= r_acc + w_prod_sh;
                default: r_acc <= r_acc;
            endcase
        end
        if (r_div) begin
            if (r_cnt == 7'd64) begin
                r_res <= r_neg ? (64'd0 - r_quo) : r_quo;
            end else if (w_rsh >= {1'b0, r_b}) begin
                r_rem <= w_rsh - {1'b0, r_b};
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_rsh;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.mul_go || i_ctrl.div_go) begin
                r_mul <= i_ctrl.mul_go;
                r_div <= i_ctrl.div_go;
                r_cnt <= '0;
            end else if (r_mul) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd3) begin
                    r_mul  <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_div) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    r_div  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.result = r_res;

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mul && r_div))
        else $error("multiply and divide active together");
    a_done_after_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_mul || r_div))
        else $error("done without an operation");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div |-> (r_cnt <= 7'd64))
        else $error("divider count overrun");

endmodule

// ===== rtl/register_alu_execute_unit_top.sv =====
// Top level of the register ALU execute unit: control sequencer, compare state and result register.
// One instruction is taken at a time: start is accepted while busy is low, and the result
// appears on o_rsp with o_done high for a single cycle; it cannot be held off. Mov, inc, dec,
// add, sub, cmp, jumps and a zero-divisor div complete from the execute state; mul waits in
// S_MD on three 32x32 partial products on one multiplier, and div waits on the divider, which
// yields one quotient bit per cycle. busy falls in the cycle o_done rises,
// so the next instruction may be started then. The register file is read on acceptance and
// written at completion; it reads as zero after reset without any clearing pass.
module register_alu_execute_unit_top #(
    parameter int REG_COUNT = rae_pkg::RAE_REG_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rae_pkg::t_req i_req,
    output logic          o_done,
    output rae_pkg::t_rsp o_rsp
);
    import rae_pkg::*;

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MD   = 3'b100
    } t_state;

    t_state      r_state;
    t_state      n_state;
    t_req        r_req;
    t_rsp        r_rsp;
    t_rsp        n_rsp;
    logic        r_done;
    logic        n_done;
    logic [1:0]  r_cmp;
    logic [1:0]  n_cmp;
    logic [AW-1:0] r_a_idx;

    logic          w_accept;
    logic [AW-1:0] w_a_idx;
    logic [AW-1:0] w_b_idx;
    logic          w_we;
    logic [63:0]   w_wdata;
    logic [63:0]   w_dst;
    logic [63:0]   w_rd_b;
    logic [63:0]   w_bval;
    logic [63:0]   w_aval;
    t_md_ctrl      w_md_ctrl;
    t_md_stat      w_md_stat;

    function automatic logic [AW-1:0] f_idx(input logic [7:0] v);
        logic [16:0] r;
        r = {9'd0, v};
        for (int k = 7; k >= 0; k--) begin
            if (r >= (17'(REG_COUNT) << k)) begin
                r = r - (17'(REG_COUNT) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    assign w_accept = start && (r_state == S_IDLE);
    assign w_a_idx  = f_idx(i_req.a_reg);
    assign w_b_idx  = f_idx(i_req.b_reg);
    assign w_bval   = r_req.b_is_imm ? r_req.b_imm : w_rd_b;
    assign w_aval   = r_req.a_is_imm ? r_req.a_imm : w_dst;

    rae_regfile #(
        .REG_COUNT (REG_COUNT),
        .AW        (AW)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_a_addr (w_a_idx),
        .i_rd_b_addr (w_b_idx),
        .i_we        (w_we),
        .i_wr_addr   (r_a_idx),
        .i_wr_data   (w_wdata),
        .o_rd_a      (w_dst),
        .o_rd_b      (w_rd_b)
    );

    rae_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_md_ctrl),
        .i_a     (w_dst),
        .i_b     (w_bval),
        .o_stat  (w_md_stat)
    );

    always_comb begin
        n_state          = r_state;
        n_rsp            = r_rsp;
        n_done           = 1'b0;
        n_cmp            = r_cmp;
        w_we             = 1'b0;
        w_wdata          = '0;
        w_md_ctrl.mul_go = 1'b0;
        w_md_ctrl.div_go = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_req.req_type)
                    OP_MOV: begin
                        w_wdata = w_bval;
                        w_we    = 1'b1;
                    end
                    OP_INC: begin
                        w_wdata = w_dst + 64'd1;
                        w_we    = 1'b1;
                    end
                    OP_DEC: begin
                        w_wdata = w_dst - 64'd1;
                        w_we    = 1'b1;
                    end
                    OP_ADD: begin
                        w_wdata = w_dst + w_bval;
                        w_we    = 1'b1;
                    end
                    OP_SUB: begin
                        w_wdata = w_dst - w_bval;
                        w_we    = 1'b1;
                    end
                    OP_MUL: begin
                        w_md_ctrl.mul_go = 1'b1;
                        n_state          = S_MD;
                        n_done           = 1'b0;
                    end
                    OP_DIV: begin
                        if (w_bval == 64'd0) begin
                            w_wdata = w_dst;
                        end else begin
                            w_md_ctrl.div_go = 1'b1;
                            n_state          = S_MD;
                            n_done           = 1'b0;
                        end
                    end
                    OP_CMP: begin
                        if (w_aval == w_bval) begin
                            n_cmp = CMP_EQ;
                        end else if ($signed(w_aval) > $signed(w_bval)) begin
                            n_cmp = CMP_GT;
                        end else begin
                            n_cmp = CMP_LT;
                        end
                    end
                    default: begin
                    end
                endcase
                n_rsp.result_value  = w_wdata;
                n_rsp.compare_state = n_cmp;
                n_rsp.div_error     = (r_req.req_type == OP_DIV) && (w_bval == 64'd0);
                case (r_req.req_type)
                    OP_JMP:  n_rsp.take_jump = 1'b1;
                    OP_JNE:  n_rsp.take_jump = (r_cmp != CMP_EQ);
                    OP_JE:   n_rsp.take_jump = (r_cmp == CMP_EQ);
                    OP_JGE:  n_rsp.take_jump = (r_cmp == CMP_EQ) || (r_cmp == CMP_GT);
                    OP_JG:   n_rsp.take_jump = (r_cmp == CMP_GT);
                    OP_JLE:  n_rsp.take_jump = (r_cmp == CMP_EQ) || (r_cmp == CMP_LT);
                    OP_JL:   n_rsp.take_jump = (r_cmp == CMP_LT);
                    default: n_rsp.take_jump = 1'b0;
                endcase
            end
            S_MD: begin
                if (w_md_stat.done) begin
                    w_wdata             = w_md_stat.result;
                    w_we                = 1'b1;
                    n_rsp.result_value  = w_md_stat.result;
                    n_rsp.compare_state = r_cmp;
                    n_rsp.take_jump     = 1'b0;
                    n_rsp.div_error     = 1'b0;
                    n_done              = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req;
            r_a_idx <= w_a_idx;
        end
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cmp   <= CMP_NE;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cmp   <= n_cmp;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but unit not busy");
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_EXEC) || ($past(r_state) == S_MD))
        else $error("done strobe without work");
    a_md_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_stat.done |-> (r_state == S_MD))
        else $error("arithmetic unit finished outside wait state");
    a_cmp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> $stable(r_cmp))
        else $error("compare state changed without cmp");

endmodule
